>>> rtl/core/fbsd_pkg.sv
// Package for the field byte stream decoder.
// Holds field kind codes, the queue entry type, byte limits and helpers.
// No dependencies.
package fbsd_pkg;

    localparam int QUEUE_DEPTH_DEF = 4;

    localparam logic [2:0] KIND_BYTE       = 3'd0;
    localparam logic [2:0] KIND_SHORT      = 3'd1;
    localparam logic [2:0] KIND_INT        = 3'd2;
    localparam logic [2:0] KIND_LONG       = 3'd3;
    localparam logic [2:0] KIND_VARINT32   = 3'd4;
    localparam logic [2:0] KIND_VARINT64   = 3'd5;
    localparam logic [2:0] KIND_FALSE_LONG = 3'd6;

    localparam logic [3:0] IDX_MAX       = 4'd15;
    localparam logic [3:0] VARINT32_MAXB = 4'd5;
    localparam logic [3:0] VARINT64_MAXB = 4'd10;

    // one classified byte, front to back
    typedef struct packed {
        logic [7:0] data_byte;
        logic [2:0] kind;
        logic [3:0] idx;
        logic       first;
        logic       last;
    } fbsd_op_t;

    function automatic logic [2:0] norm_kind(input logic [2:0] k);
        logic [2:0] r;
        r = (k == 3'd7) ? KIND_BYTE : k;
        return r;
    endfunction

    function automatic logic [3:0] fixed_len(input logic [2:0] k);
        logic [3:0] r;
        unique case (k)
            KIND_SHORT:      r = 4'd2;
            KIND_INT:        r = 4'd4;
            KIND_LONG:       r = 4'd8;
            KIND_FALSE_LONG: r = 4'd8;
            default:         r = 4'd1;
        endcase
        return r;
    endfunction

    function automatic logic is_varint(input logic [2:0] k);
        return (k == KIND_VARINT32) || (k == KIND_VARINT64);
    endfunction

endpackage

>>> rtl/core/fbsd_front.sv
// Front end: accepts bytes, tracks field boundaries, tags each request.
// Depends on fbsd_pkg.
module fbsd_front (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               push,
    input  logic [7:0]         data_byte,
    input  logic [2:0]         field_kind,
    output fbsd_pkg::fbsd_op_t op
);
    import fbsd_pkg::*;

    logic       in_field_reg, in_field_next;
    logic [2:0] kind_reg, kind_next;
    logic [3:0] cnt_reg, cnt_next;

    logic [2:0] kind_cur;
    logic [3:0] idx_cur;
    logic [4:0] idx_inc;
    logic       last_cur;

    always_comb
    begin
        kind_cur = in_field_reg ? kind_reg : norm_kind(field_kind);
        idx_cur  = in_field_reg ? cnt_reg : 4'd0;
        idx_inc  = {1'b0, idx_cur} + 5'd1;
        if (is_varint(kind_cur))
        begin
            last_cur = ~data_byte[7];
        end
        else
        begin
            last_cur = idx_inc >= {1'b0, fixed_len(kind_cur)};
        end

        op.data_byte = data_byte;
        op.kind      = kind_cur;
        op.idx       = idx_cur;
        op.first     = ~in_field_reg;
        op.last      = last_cur;

        in_field_next = in_field_reg;
        kind_next     = kind_reg;
        cnt_next      = cnt_reg;
        if (push)
        begin
            if (last_cur)
            begin
                in_field_next = 1'b0;
                kind_next     = KIND_BYTE;
                cnt_next      = 4'd0;
            end
            else
            begin
                in_field_next = 1'b1;
                kind_next     = kind_cur;
                cnt_next      = (idx_cur == IDX_MAX) ? IDX_MAX : idx_inc[3:0];
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_field_reg <= 1'b0;
            kind_reg     <= KIND_BYTE;
            cnt_reg      <= 4'd0;
        end
        else
        begin
            in_field_reg <= in_field_next;
            kind_reg     <= kind_next;
            cnt_reg      <= cnt_next;
        end
    end

endmodule

>>> rtl/core/fbsd_queue.sv
// Short request queue between front and back end.
// Depends on fbsd_pkg.
module fbsd_queue #(
    parameter int DEPTH = fbsd_pkg::QUEUE_DEPTH_DEF
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               push,
    input  fbsd_pkg::fbsd_op_t push_op,
    input  logic               pop,
    output fbsd_pkg::fbsd_op_t head_op,
    output logic               empty,
    output logic               full
);
    import fbsd_pkg::*;

    localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);
    localparam logic [PW-1:0] LAST_PTR = PW'(DEPTH - 1);
    localparam logic [CW-1:0] FULL_CNT = CW'(DEPTH);

    fbsd_op_t      entry_reg [DEPTH];
    logic [PW-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PW-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CW-1:0] cnt_reg, cnt_next;

    always_comb
    begin
        empty   = (cnt_reg == '0);
        full    = (cnt_reg == FULL_CNT);
        head_op = entry_reg[rd_ptr_reg];

        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        if (push)
        begin
            wr_ptr_next = (wr_ptr_reg == LAST_PTR) ? '0 : wr_ptr_reg + PW'(1);
        end
        if (pop)
        begin
            rd_ptr_next = (rd_ptr_reg == LAST_PTR) ? '0 : rd_ptr_reg + PW'(1);
        end
        unique case ({push, pop})
            2'b10:   cnt_next = cnt_reg + CW'(1);
            2'b01:   cnt_next = cnt_reg - CW'(1);
            default: cnt_next = cnt_reg;
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            entry_reg[wr_ptr_reg] <= push_op;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            cnt_reg    <= cnt_next;
        end
    end

endmodule

>>> rtl/core/fbsd_back.sv
// Back end: folds requests into the accumulator, holds the output register.
// Depends on fbsd_pkg.
module fbsd_back (
    input  logic               clk,
    input  logic               rst_n,
    input  fbsd_pkg::fbsd_op_t head_op,
    input  logic               empty,
    output logic               pop,
    output logic               out_valid,
    input  logic               out_ready,
    output logic [63:0]        out_value,
    output logic [2:0]         out_kind,
    output logic               out_overlong
);
    import fbsd_pkg::*;

    logic [63:0] acc_reg, acc_next;
    logic        ovl_reg, ovl_next;
    logic        out_valid_reg, out_valid_next;
    logic [63:0] out_value_reg;
    logic [2:0]  out_kind_reg;
    logic        out_ovl_reg;

    logic [63:0] base;
    logic [63:0] group;
    logic [63:0] value;
    logic [6:0]  shamt;
    logic [3:0]  maxb;
    logic        in_range;

    always_comb
    begin
        base     = head_op.first ? 64'd0 : acc_reg;
        shamt    = {head_op.idx, 3'b000} - {3'b000, head_op.idx};
        group    = {57'd0, head_op.data_byte[6:0]} << shamt[5:0];
        maxb     = (head_op.kind == KIND_VARINT32) ? VARINT32_MAXB : VARINT64_MAXB;
        in_range = head_op.idx < maxb;

        acc_next = acc_reg;
        ovl_next = ovl_reg;
        value    = 64'd0;
        if (is_varint(head_op.kind))
        begin
            acc_next = in_range ? (base | group) : base;
            if (head_op.kind == KIND_VARINT32)
            begin
                acc_next[63:32] = 32'd0;
            end
            ovl_next = (head_op.first ? 1'b0 : ovl_reg) | ~in_range;
            value    = acc_next;
        end
        else
        begin
            acc_next = {base[55:0], head_op.data_byte};
            ovl_next = 1'b0;
            value    = acc_next;
            if (head_op.kind == KIND_FALSE_LONG)
            begin
                value[63:32] = 32'd0;
            end
        end

        pop = ~empty & (~head_op.last | ~out_valid_reg | out_ready);

        out_valid_next = out_valid_reg;
        if (pop && head_op.last)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (pop)
        begin
            acc_reg <= acc_next;
        end
        if (pop && head_op.last)
        begin
            out_value_reg <= value;
            out_kind_reg  <= head_op.kind;
            out_ovl_reg   <= ovl_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ovl_reg       <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (pop)
            begin
                ovl_reg <= ovl_next;
            end
            out_valid_reg <= out_valid_next;
        end
    end

    assign out_valid    = out_valid_reg;
    assign out_value    = out_value_reg;
    assign out_kind     = out_kind_reg;
    assign out_overlong = out_ovl_reg;

endmodule

>>> rtl/core/field_byte_stream_decoder.sv
// Field byte stream decoder: varint and big-endian fixed fields, one byte per request.
// A field's result passes through the queue and the back end output register to m_tvalid.
// Throughput: one byte per cycle while s_tready is high; a result waiting on m_tready
// stalls the back end at a field's last byte, and the queue then fills and drops s_tready.
// Reset: rst_n asynchronous, active low; clears field tracking, queue and output valid.
// Depends on fbsd_pkg, fbsd_front, fbsd_queue, fbsd_back.
module field_byte_stream_decoder #(
    parameter int QUEUE_DEPTH = fbsd_pkg::QUEUE_DEPTH_DEF
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,   // [7:0] data_byte
    input  logic [2:0]  s_tuser,   // [2:0] field_kind
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [63:0] m_tdata,   // [63:0] field_value
    output logic [3:0]  m_tuser    // [2:0] decoded_kind, [3] overlong
);
    import fbsd_pkg::*;

    fbsd_op_t front_op;
    fbsd_op_t head_op;
    logic     push;
    logic     pop;
    logic     q_empty;
    logic     q_full;

    assign s_tready = ~q_full;
    assign push     = s_tvalid & ~q_full;

    fbsd_front u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (push),
        .data_byte  (s_tdata),
        .field_kind (s_tuser),
        .op         (front_op)
    );

    fbsd_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .clk     (clk),
        .rst_n   (rst_n),
        .push    (push),
        .push_op (front_op),
        .pop     (pop),
        .head_op (head_op),
        .empty   (q_empty),
        .full    (q_full)
    );

    fbsd_back u_back (
        .clk          (clk),
        .rst_n        (rst_n),
        .head_op      (head_op),
        .empty        (q_empty),
        .pop          (pop),
        .out_valid    (m_tvalid),
        .out_ready    (m_tready),
        .out_value    (m_tdata),
        .out_kind     (m_tuser[2:0]),
        .out_overlong (m_tuser[3])
    );

    a_ovl_varint_only: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && m_tuser[3] |-> m_tuser[2:0] == KIND_VARINT32 ||
                                   m_tuser[2:0] == KIND_VARINT64)
        else $error("overlong flag on a fixed-width field");

    a_no_kind7: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> m_tuser[2:0] != 3'd7)
        else $error("undefined kind reported");

    a_narrow_upper_zero: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && (m_tuser[2:0] == KIND_VARINT32 || m_tuser[2:0] == KIND_FALSE_LONG ||
                     m_tuser[2:0] == KIND_INT) |-> m_tdata[63:32] == 32'd0)
        else $error("32-bit field has upper bits set");

    a_byte_upper_zero: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && m_tuser[2:0] == KIND_BYTE |-> m_tdata[63:8] == 56'd0)
        else $error("byte field has upper bits set");

endmodule

>>> sim/field_byte_stream_decoder_check.sv
`timescale 1ns / 100ps
// Checker for the field byte stream decoder: watches both stream channels,
// predicts each decoded field from the accepted bytes and compares results.
// Depends on fbsd_pkg for the field kind codes.
module field_byte_stream_decoder_check (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    input  logic        s_tready,
    input  logic [7:0]  s_tdata,
    input  logic [2:0]  s_tuser,
    input  logic        m_tvalid,
    input  logic        m_tready,
    input  logic [63:0] m_tdata,
    input  logic [3:0]  m_tuser,
    output int          fail_count,
    output int          outstanding
);
    import fbsd_pkg::*;

    localparam logic [2:0] KIND_UNUSED = 3'd7;

    typedef struct packed {
        logic [63:0] value;
        logic [2:0]  kind;
        logic        overlong;
    } decoded_field_t;

    decoded_field_t expected_fields[$];
    decoded_field_t want;

    logic [63:0] acc;
    logic [3:0]  taken;
    logic [2:0]  cur_kind;
    logic        in_field;
    logic        ovl_seen;
    int          mismatches = 0;

    assign fail_count = mismatches;

    task automatic report(input string what, input logic [63:0] got, input logic [63:0] exp_val);
        $display("ERROR %0t: %s got 0x%0h, expected 0x%0h", $time, what, got, exp_val);
        mismatches++;
    endtask

    task automatic decode_byte(input logic [7:0] b, input logic [2:0] k);
        logic           done;
        logic [63:0]    value;
        logic [63:0]    grp;
        logic [3:0]     limit;
        decoded_field_t r;
        if (!in_field)
        begin
            cur_kind = (k == KIND_UNUSED) ? KIND_BYTE : k;
            acc      = '0;
            taken    = '0;
            ovl_seen = 1'b0;
            in_field = 1'b1;
        end
        if (cur_kind == KIND_VARINT32 || cur_kind == KIND_VARINT64)
        begin
            limit = (cur_kind == KIND_VARINT32) ? VARINT32_MAXB : VARINT64_MAXB;
            if (taken < limit)
            begin
                grp = {57'd0, b[6:0]} << (7 * taken);
                acc = acc | grp;
                if (cur_kind == KIND_VARINT32)
                    acc[63:32] = '0;
            end
            else
                ovl_seen = 1'b1;
            done  = !b[7];
            value = acc;
        end
        else
        begin
            acc = {acc[55:0], b};
            case (cur_kind)
                KIND_SHORT:                limit = 4'd2;
                KIND_INT:                  limit = 4'd4;
                KIND_LONG, KIND_FALSE_LONG: limit = 4'd8;
                default:                   limit = 4'd1;
            endcase
            done  = (int'(taken) + 1 >= int'(limit));
            value = acc;
            if (cur_kind == KIND_FALSE_LONG)
                value[63:32] = '0;
        end
        if (taken != IDX_MAX)
            taken++;
        if (done)
        begin
            r.value    = value;
            r.kind     = cur_kind;
            r.overlong = ovl_seen;
            expected_fields.push_back(r);
            acc      = '0;
            taken    = '0;
            cur_kind = KIND_BYTE;
            in_field = 1'b0;
            ovl_seen = 1'b0;
        end
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            acc      = '0;
            taken    = '0;
            cur_kind = KIND_BYTE;
            in_field = 1'b0;
            ovl_seen = 1'b0;
            expected_fields.delete();
            outstanding <= 0;
        end
        else
        begin
            if (s_tvalid && s_tready)
                decode_byte(s_tdata, s_tuser);
            if (m_tvalid && m_tready)
            begin
                if (expected_fields.size() == 0)
                    report("result with no request pending", m_tdata, '0);
                else
                begin
                    want = expected_fields.pop_front();
                    if (m_tdata !== want.value)
                        report("field_value", m_tdata, want.value);
                    if (m_tuser[2:0] !== want.kind)
                        report("decoded_kind", 64'(m_tuser[2:0]), 64'(want.kind));
                    if (m_tuser[3] !== want.overlong)
                        report("overlong", 64'(m_tuser[3]), 64'(want.overlong));
                end
            end
            outstanding <= expected_fields.size();
        end
    end

endmodule

>>> sim/field_byte_stream_decoder_test.sv
`timescale 1ns / 100ps
// Testbench top for the field byte stream decoder: drives byte requests and
// result back-pressure, and gives the verdict.
// Depends on fbsd_pkg, field_byte_stream_decoder and field_byte_stream_decoder_check.
module field_byte_stream_decoder_test;
    import fbsd_pkg::*;

    localparam int         CYCLE_LIMIT = 1_000_000;
    localparam int         HOLD_CYCLES = 300;
    localparam logic [2:0] KIND_UNUSED = 3'd7;

    logic        clk      = 1'b0;
    logic        rst_n    = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [7:0]  s_tdata  = '0;
    logic [2:0]  s_tuser  = '0;
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [63:0] m_tdata;
    logic [3:0]  m_tuser;

    int   fail_count;
    int   outstanding;
    int   cycles       = 0;
    int   bytes_sent   = 0;
    logic quiet        = 1'b0;
    int   holds_asked  = 0;
    int   holds_done   = 0;
    int   hold_left    = 0;
    int   rx_idle_left = 0;

    always
    begin
        #4 clk = 1'b1;
        #4 clk = 1'b0;
    end

    field_byte_stream_decoder dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser)
    );

    field_byte_stream_decoder_check checker_inst (
        .clk         (clk),
        .rst_n       (rst_n),
        .s_tvalid    (s_tvalid),
        .s_tready    (s_tready),
        .s_tdata     (s_tdata),
        .s_tuser     (s_tuser),
        .m_tvalid    (m_tvalid),
        .m_tready    (m_tready),
        .m_tdata     (m_tdata),
        .m_tuser     (m_tuser),
        .fail_count  (fail_count),
        .outstanding (outstanding)
    );

    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles >= CYCLE_LIMIT)
        begin
            $display("Test completed with failures");
            $finish;
        end
    end

    // mostly no gap, some short, a few long
    function automatic int gap_len();
        int r;
        r = $urandom_range(0, 99);
        if (r < 60)
            return 0;
        if (r < 92)
            return $urandom_range(1, 3);
        return $urandom_range(4, 30);
    endfunction

    // result side back-pressure, with a long hold on request
    always @(posedge clk)
    begin : rx_side
        int g;
        if (!rst_n)
            m_tready <= 1'b0;
        else if (hold_left > 0)
        begin
            m_tready <= 1'b0;
            hold_left--;
        end
        else if (holds_done != holds_asked)
        begin
            holds_done++;
            hold_left = HOLD_CYCLES - 1;
            m_tready <= 1'b0;
        end
        else if (rx_idle_left > 0)
        begin
            m_tready <= 1'b0;
            rx_idle_left--;
        end
        else
        begin
            g = quiet ? 0 : gap_len();
            if (g == 0)
                m_tready <= 1'b1;
            else
            begin
                m_tready <= 1'b0;
                rx_idle_left = g - 1;
            end
        end
    end

    task automatic push(input logic [7:0] b, input logic [2:0] k);
        int g;
        s_tvalid <= 1'b1;
        s_tdata  <= b;
        s_tuser  <= k;
        do
            @(negedge clk);
        while (!s_tready);
        @(posedge clk);
        bytes_sent++;
        g = quiet ? 0 : gap_len();
        if (g > 0)
        begin
            s_tvalid <= 1'b0;
            repeat (g) @(posedge clk);
        end
    endtask

    // one whole field; kind only on the first byte, noise on tuser after it
    task automatic send_field(input logic [2:0] k);
        int         n;
        int         maxb;
        int         pattern;
        logic [7:0] b;
        maxb = 0;
        case (k)
            KIND_SHORT:                 n = 2;
            KIND_INT:                   n = 4;
            KIND_LONG, KIND_FALSE_LONG: n = 8;
            KIND_VARINT32:              maxb = 5;
            KIND_VARINT64:              maxb = 10;
            default:                    n = 1;
        endcase
        if (maxb != 0)
            n = ($urandom_range(0, 9) == 0) ? $urandom_range(maxb + 1, maxb + 8)
                                            : $urandom_range(1, maxb);
        pattern = $urandom_range(0, 7);
        for (int i = 0; i < n; i++)
        begin
            if (pattern == 0)
                b = 8'h00;
            else if (pattern == 1)
                b = 8'hFF;
            else
                b = 8'($urandom_range(0, 255));
            if (maxb != 0)
                b[7] = (i != n - 1);
            push(b, (i == 0) ? k : 3'($urandom_range(0, 7)));
        end
    endtask

    task automatic random_item();
        if ($urandom_range(0, 99) < 85)
            send_field(3'($urandom_range(0, 7)));
        else
            push(8'($urandom_range(0, 255)), 3'($urandom_range(0, 7)));
    endtask

    task automatic wait_drained();
        repeat (2) @(posedge clk);
        while (outstanding != 0)
            @(posedge clk);
    endtask

    initial
    begin
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        push(8'h00, KIND_BYTE);
        push(8'hFF, KIND_UNUSED);
        push(8'hFF, KIND_SHORT);
        push(8'hFF, KIND_UNUSED);
        push(8'h80, KIND_INT);
        push(8'h00, KIND_BYTE);
        push(8'h00, KIND_BYTE);
        push(8'h01, KIND_BYTE);
        for (int i = 0; i < 8; i++)
            push(8'hFF, KIND_LONG);
        for (int i = 0; i < 8; i++)
            push(8'(8'hF1 + i), KIND_FALSE_LONG);
        // varint32 with bits past 32 in the fifth group
        for (int i = 0; i < 4; i++)
            push(8'hFF, KIND_VARINT32);
        push(8'h7F, KIND_VARINT32);
        // varint32 running one byte past its limit
        for (int i = 0; i < 5; i++)
            push(8'h80, KIND_VARINT32);
        push(8'h01, KIND_BYTE);
        // varint64 with only bit 63 kept from the tenth byte
        for (int i = 0; i < 9; i++)
            push(8'hFF, KIND_VARINT64);
        push(8'h7F, KIND_VARINT64);

        while (bytes_sent < 700)
            random_item();

        quiet <= 1'b1;
        while (bytes_sent < 1000)
            random_item();

        // results back up while byte fields keep coming
        holds_asked <= holds_asked + 1;
        for (int i = 0; i < 40; i++)
            push(8'($urandom_range(0, 255)), KIND_BYTE);
        s_tvalid <= 1'b0;
        quiet <= 1'b0;

        wait_drained();
        repeat (5) @(posedge clk);

        while (bytes_sent < 1850)
            random_item();
        s_tvalid <= 1'b0;

        wait_drained();
        repeat (20) @(posedge clk);
        if (fail_count == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end

endmodule
